// ===== rtl/dgrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dgrs_pkg;

  localparam int CENTER_FRAC_BITS = 16;
  localparam int TABLE_ENTRIES    = 13;
  localparam int EXP_DEGREE       = 16;

  localparam int CENTER_W  = 32;
  localparam int RAND_W    = 64;
  localparam int ACC_W     = 53;
  localparam int SAMPLE_W  = 17;
  localparam int CFG_W     = 32;
  localparam int Z0_W      = 4;
  localparam int S_W       = 6;
  localparam int R_W       = 56;
  localparam int WORD_W    = 64;

  // |z - u| < 15 * 2^CFB
  localparam int AD_W   = CENTER_FRAC_BITS + 4;
  localparam int SQ_W   = 2 * AD_W;
  localparam int PP_W   = SQ_W + CFG_W / 2;
  localparam int PROD_W = SQ_W + CFG_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam int DIV_STAGES = S_W;
  localparam int CHUNK_W    = 16;
  localparam int N_CHUNK    = WORD_W / CHUNK_W;
  localparam int REM_W      = 4;
  localparam int V_W        = REM_W + CHUNK_W;
  localparam int RECIP_SH   = 25;
  localparam int RECIP_W    = RECIP_SH + 1;
  localparam int K_W        = 5;
  localparam int HP_W       = 120;

  localparam int THR_LIMIT = 54;
  localparam int THR_BIAS  = 10;

  localparam logic [WORD_W-1:0] LN2_Q56 = 64'h00B1_7217_F7D1_CF7A;
  localparam logic [WORD_W-1:0] ONE_Q63 = 64'h8000_0000_0000_0000;
  localparam logic [WORD_W-1:0] LN2_SAT = LN2_Q56 << DIV_STAGES;

  localparam logic [RAND_W-1:0] CDT [TABLE_ENTRIES] = '{
    64'd8562458705743934607,  64'd14988938141546119862,
    64'd17705984313312429518, 64'd18353082494776078532,
    64'd18439897061947435901, 64'd18446457975170112665,
    64'd18446737284374178633, 64'd18446743982533372247,
    64'd18446744073018029834, 64'd18446744073706592852,
    64'd18446744073709544480, 64'd18446744073709551607,
    64'd18446744073709551615
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [ACC_W-1:0]    acc;
    logic [S_W-1:0]      s;
    logic                sat;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [Z0_W-1:0]   z0;
    logic [AD_W-1:0]   ad;
  } entry_t;

  // ceil(2^25 / k): exact floor division of 20-bit values by k
  function automatic logic [RECIP_W-1:0] recip_lut(input logic [K_W-1:0] k);
    logic [RECIP_W-1:0] m;
    case (k)
      5'd1:    m = 26'd33554432;
      5'd2:    m = 26'd16777216;
      5'd3:    m = 26'd11184811;
      5'd4:    m = 26'd8388608;
      5'd5:    m = 26'd6710887;
      5'd6:    m = 26'd5592406;
      5'd7:    m = 26'd4793491;
      5'd8:    m = 26'd4194304;
      5'd9:    m = 26'd3728271;
      5'd10:   m = 26'd3355444;
      5'd11:   m = 26'd3050403;
      5'd12:   m = 26'd2796203;
      5'd13:   m = 26'd2581111;
      5'd14:   m = 26'd2396746;
      5'd15:   m = 26'd2236963;
      5'd16:   m = 26'd2097152;
      default: m = 26'd33554432;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dgrs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface dgrs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center;
  logic [63:0]        base_random;
  logic               sign_bit;
  logic [52:0]        accept_random;
  modport source (output valid, center, base_random, sign_bit, accept_random, input ready);
  modport sink   (input valid, center, base_random, sign_bit, accept_random, output ready);
endinterface

interface dgrs_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] sample;
  logic               accepted;
  modport source (output valid, sample, accepted, input ready);
  modport sink   (input valid, sample, accepted, output ready);
endinterface

interface dgrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/dgrs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dgrs_front (
  input  logic signed [dgrs_pkg::CENTER_W-1:0] center,
  input  logic [dgrs_pkg::RAND_W-1:0]          base_random,
  input  logic                                 sign_bit,
  input  logic [dgrs_pkg::ACC_W-1:0]           accept_random,
  output dgrs_pkg::entry_t                     entry
);
  import dgrs_pkg::*;

  logic [Z0_W-1:0]             z0;
  logic [CENTER_FRAC_BITS-1:0] frac;
  logic signed [5:0]           off;
  logic signed [CENTER_W-1:0]  uf;
  logic signed [CENTER_W-1:0]  z;
  logic [AD_W-1:0]             ad;

  always_comb begin
    z0 = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      z0 = z0 + Z0_W'(base_random >= CDT[i]);
    end
    frac = center[CENTER_FRAC_BITS-1:0];
    off  = sign_bit ? (6'(z0) + 6'd1) : (6'd0 - 6'(z0));
    uf   = center >>> CENTER_FRAC_BITS;
    z    = uf + CENTER_W'(off);
    // distance to the center, always positive-side magnitude
    if (sign_bit) begin
      ad = ((AD_W'(z0) + AD_W'(1)) << CENTER_FRAC_BITS) - AD_W'(frac);
    end else begin
      ad = (AD_W'(z0) << CENTER_FRAC_BITS) | AD_W'(frac);
    end
    entry.side.sample = z[SAMPLE_W-1:0];
    entry.side.acc    = accept_random;
    entry.side.s      = '0;
    entry.side.sat    = 1'b0;
    entry.z0          = z0;
    entry.ad          = ad;
  end

endmodule
`default_nettype wire

// ===== rtl/dgrs_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dgrs_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dgrs_pkg::entry_t wdata,
  input  logic             pop,
  output dgrs_pkg::entry_t rdata,
  output logic             full,
  output logic             empty
);
  import dgrs_pkg::*;

  entry_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_CW-1:0]   count_r;
  logic [FIFO_CW-1:0]   count_nxt;

  assign full  = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + FIFO_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dgrs_exp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dgrs_exp_step (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [dgrs_pkg::K_W-1:0]    step_k,
  input  logic                        in_vld,
  input  dgrs_pkg::side_t             in_side,
  input  logic [dgrs_pkg::R_W-1:0]    in_r,
  input  logic [dgrs_pkg::WORD_W-1:0] in_y,
  output logic                        out_vld,
  output dgrs_pkg::side_t             out_side,
  output logic [dgrs_pkg::R_W-1:0]    out_r,
  output logic [dgrs_pkg::WORD_W-1:0] out_y
);
  import dgrs_pkg::*;

  // y' = 1 - (r*y)/k, Q63; r arrives as Q56 so the product shifts by 56
  logic [RECIP_W-1:0] recip;
  assign recip = recip_lut(step_k);

  logic               e1_vld_r;
  side_t              e1_side_r;
  logic [R_W-1:0]     e1_r_r;
  logic [63:0]        pp00_r, pp01_r;
  logic [55:0]        pp10_r, pp11_r;

  logic               e2_vld_r;
  side_t              e2_side_r;
  logic [R_W-1:0]     e2_r_r;
  logic [WORD_W-1:0]  e2_p_r;
  logic [HP_W-1:0]    hp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
    end else if (en) begin
      e1_vld_r <= in_vld;
      e2_vld_r <= e1_vld_r;
    end
  end

  assign hp_nxt = (HP_W'(pp11_r) << 64) + (HP_W'(pp01_r) << 32)
                + (HP_W'(pp10_r) << 32) + HP_W'(pp00_r);

  always_ff @(posedge clk) begin
    if (en) begin
      e1_side_r <= in_side;
      e1_r_r    <= in_r;
      pp00_r    <= in_r[31:0] * in_y[31:0];
      pp01_r    <= in_r[31:0] * in_y[63:32];
      pp10_r    <= in_r[55:32] * in_y[31:0];
      pp11_r    <= in_r[55:32] * in_y[63:32];
      e2_side_r <= e1_side_r;
      e2_r_r    <= e1_r_r;
      e2_p_r    <= hp_nxt[HP_W-1:56];
    end
  end

  // long division by k, one 16-bit digit per stage
  logic              lk_vld  [N_CHUNK+1];
  side_t             lk_side [N_CHUNK+1];
  logic [R_W-1:0]    lk_r    [N_CHUNK+1];
  logic [WORD_W-1:0] lk_p    [N_CHUNK+1];
  logic [WORD_W-1:0] lk_q    [N_CHUNK+1];
  logic [REM_W-1:0]  lk_rem  [N_CHUNK+1];

  logic              ch_vld_r  [N_CHUNK];
  side_t             ch_side_r [N_CHUNK];
  logic [R_W-1:0]    ch_r_r    [N_CHUNK];
  logic [WORD_W-1:0] ch_p_r    [N_CHUNK];
  logic [WORD_W-1:0] ch_q_r    [N_CHUNK];
  logic [REM_W-1:0]  ch_rem_r  [N_CHUNK];

  assign lk_vld[0]  = e2_vld_r;
  assign lk_side[0] = e2_side_r;
  assign lk_r[0]    = e2_r_r;
  assign lk_p[0]    = e2_p_r;
  assign lk_q[0]    = '0;
  assign lk_rem[0]  = '0;

  for (genvar c = 0; c < N_CHUNK; c++) begin : g_chunk
    logic [V_W-1:0]           v;
    logic [V_W+RECIP_W-1:0]   mp;
    logic [CHUNK_W-1:0]       qd;
    logic [V_W:0]             back;
    logic [WORD_W-1:0]        q_nxt;
    logic [WORD_W-1:0]        store_nxt;

    always_comb begin
      v         = {lk_rem[c], lk_p[c][WORD_W-1-CHUNK_W*c -: CHUNK_W]};
      mp        = (V_W+RECIP_W)'(v) * (V_W+RECIP_W)'(recip);
      qd        = mp[RECIP_SH +: CHUNK_W];
      back      = (V_W+1)'(v) - (V_W+1)'(qd) * (V_W+1)'(step_k);
      q_nxt     = lk_q[c] | (WORD_W'(qd) << (WORD_W - CHUNK_W * (c + 1)));
      store_nxt = (c == N_CHUNK - 1) ? (ONE_Q63 - q_nxt) : q_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ch_vld_r[c] <= 1'b0;
      end else if (en) begin
        ch_vld_r[c] <= lk_vld[c];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ch_side_r[c] <= lk_side[c];
        ch_r_r[c]    <= lk_r[c];
        ch_p_r[c]    <= lk_p[c];
        ch_q_r[c]    <= store_nxt;
        ch_rem_r[c]  <= back[REM_W-1:0];
      end
    end

    assign lk_vld[c+1]  = ch_vld_r[c];
    assign lk_side[c+1] = ch_side_r[c];
    assign lk_r[c+1]    = ch_r_r[c];
    assign lk_p[c+1]    = ch_p_r[c];
    assign lk_q[c+1]    = ch_q_r[c];
    assign lk_rem[c+1]  = ch_rem_r[c];
  end

  assign out_vld  = lk_vld[N_CHUNK];
  assign out_side = lk_side[N_CHUNK];
  assign out_r    = lk_r[N_CHUNK];
  assign out_y    = lk_q[N_CHUNK];

endmodule
`default_nettype wire

// ===== rtl/dgrs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dgrs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr,
  input  logic [dgrs_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        q_empty,
  input  dgrs_pkg::entry_t            q_rdata,
  output logic                        q_pop,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [dgrs_pkg::SAMPLE_W-1:0] out_sample,
  output logic                        out_accepted
);
  import dgrs_pkg::*;

  logic [CFG_W-1:0] inv_r;
  logic             adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= '0;
    end else if (cfg_wr) begin
      inv_r <= cfg_data;
    end
  end

  logic out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic out_accepted_r;

  // whole pipeline moves together; stalls only on a held result
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && !q_empty;

  // weight: (|d|^2 - z0^2 * 2^2F) * inv, rescaled to Q56
  logic             p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r;
  side_t            p1_side_r, p2_side_r, p3_side_r, p4_side_r;
  logic [SQ_W-1:0]  p1_adsq_r;
  logic [7:0]       p1_z0sq_r;
  logic [SQ_W-1:0]  p2_negx_r;
  logic [PP_W-1:0]  p3_lo_r, p3_hi_r;
  logic [WORD_W-1:0] p4_y_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W+23:0] ext_nxt;

  assign prod_nxt = PROD_W'(p3_lo_r) + (PROD_W'(p3_hi_r) << (CFG_W / 2));
  assign ext_nxt  = {prod_nxt, 24'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= !q_empty;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_side_r <= q_rdata.side;
      p1_adsq_r <= SQ_W'(q_rdata.ad) * SQ_W'(q_rdata.ad);
      p1_z0sq_r <= 8'(q_rdata.z0) * 8'(q_rdata.z0);
      p2_side_r <= p1_side_r;
      p2_negx_r <= p1_adsq_r - (SQ_W'(p1_z0sq_r) << (2 * CENTER_FRAC_BITS));
      p3_side_r <= p2_side_r;
      p3_lo_r   <= PP_W'(p2_negx_r) * PP_W'(inv_r[CFG_W/2-1:0]);
      p3_hi_r   <= PP_W'(p2_negx_r) * PP_W'(inv_r[CFG_W-1:CFG_W/2]);
      p4_side_r <= p3_side_r;
      p4_y_r    <= ext_nxt[2*CENTER_FRAC_BITS +: WORD_W];
    end
  end

  // range reduction: s = y / ln2 one quotient bit per stage
  logic              dv_vld_r  [DIV_STAGES];
  side_t             dv_side_r [DIV_STAGES];
  logic [WORD_W-1:0] dv_rem_r  [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic              v_in;
    side_t             sd_in;
    side_t             sd_nxt;
    logic [WORD_W-1:0] rem_in;
    logic [WORD_W-1:0] dvs;
    logic              ge;

    if (g == 0) begin : g_first
      assign v_in   = p4_vld_r;
      assign sd_in  = p4_side_r;
      assign rem_in = p4_y_r;
    end else begin : g_rest
      assign v_in   = dv_vld_r[g-1];
      assign sd_in  = dv_side_r[g-1];
      assign rem_in = dv_rem_r[g-1];
    end

    assign dvs = LN2_Q56 << (DIV_STAGES - 1 - g);
    assign ge  = (rem_in >= dvs);

    always_comb begin
      sd_nxt = sd_in;
      sd_nxt.s[DIV_STAGES-1-g] = ge;
      if (g == 0) begin
        sd_nxt.sat = (rem_in >= LN2_SAT);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[g] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side_r[g] <= sd_nxt;
        dv_rem_r[g]  <= ge ? (rem_in - dvs) : rem_in;
      end
    end
  end

  // exp(-r) Horner chain, k = 16 down to 1
  logic              ex_vld  [EXP_DEGREE+1];
  side_t             ex_side [EXP_DEGREE+1];
  logic [R_W-1:0]    ex_r    [EXP_DEGREE+1];
  logic [WORD_W-1:0] ex_y    [EXP_DEGREE+1];

  assign ex_vld[0]  = dv_vld_r[DIV_STAGES-1];
  assign ex_side[0] = dv_side_r[DIV_STAGES-1];
  assign ex_r[0]    = dv_rem_r[DIV_STAGES-1][R_W-1:0];
  assign ex_y[0]    = ONE_Q63;

  for (genvar g = 0; g < EXP_DEGREE; g++) begin : g_exp
    dgrs_exp_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .step_k   (K_W'(EXP_DEGREE - g)),
      .in_vld   (ex_vld[g]),
      .in_side  (ex_side[g]),
      .in_r     (ex_r[g]),
      .in_y     (ex_y[g]),
      .out_vld  (ex_vld[g+1]),
      .out_side (ex_side[g+1]),
      .out_r    (ex_r[g+1]),
      .out_y    (ex_y[g+1])
    );
  end

  // threshold and acceptance into the output word register
  side_t             t_side;
  logic [WORD_W-1:0] thr;
  logic [S_W:0]      shamt;
  logic              acc_nxt;

  assign t_side = ex_side[EXP_DEGREE];

  always_comb begin
    shamt = (S_W+1)'(t_side.s) + (S_W+1)'(THR_BIAS);
    if (t_side.sat || (t_side.s >= S_W'(THR_LIMIT))) begin
      thr = '0;
    end else begin
      thr = ex_y[EXP_DEGREE] >> shamt;
    end
    acc_nxt = (WORD_W'(t_side.acc) < thr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ex_vld[EXP_DEGREE];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sample_r   <= t_side.sample;
      out_accepted_r <= acc_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_accepted = out_accepted_r;

`ifndef ASSERT_OFF
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> p1_vld_r)
    else $error("popped word did not enter the pipeline");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(p4_vld_r) && $stable(dv_vld_r[DIV_STAGES-1]))
    else $error("pipeline moved while stalled");

  a_sat_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    t_side.sat |-> !acc_nxt)
    else $error("saturated weight accepted");
`endif

endmodule
`default_nettype wire

// ===== rtl/discrete_gaussian_rejection_sampler_unit.sv =====
// Pipeline stages from queue read to result valid: queue read and weight 4,
//   range reduction 6, exp chain 16 steps x 6 stages, output register 1.
// Throughput: one attempt per cycle; the back pipeline advances as a whole
//   whenever the output register is empty or being taken.
// Reset: synchronous, active low; clears valid bits, queue pointers and the
//   inv_r register (to 0).
`timescale 1ns / 1ps
`default_nettype none
module discrete_gaussian_rejection_sampler_unit (
  input  logic        clk,
  input  logic        rst_n,
  dgrs_in_if.sink     in_ch,
  dgrs_out_if.source  out_ch,
  dgrs_cfg_if.sink    cfg_ch
);
  import dgrs_pkg::*;

  entry_t           f_entry;
  entry_t           q_rdata;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic             q_push;
  logic [SAMPLE_W-1:0] sample_w;

  assign in_ch.ready  = !q_full;
  assign q_push       = in_ch.valid && !q_full;
  assign cfg_ch.ready = 1'b1;

  dgrs_front u_front (
    .center        (in_ch.center),
    .base_random   (in_ch.base_random),
    .sign_bit      (in_ch.sign_bit),
    .accept_random (in_ch.accept_random),
    .entry         (f_entry)
  );

  dgrs_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (f_entry),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  dgrs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr       (cfg_ch.valid),
    .cfg_data     (cfg_ch.data),
    .q_empty      (q_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_sample   (sample_w),
    .out_accepted (out_ch.accepted)
  );

  assign out_ch.sample = sample_w;

endmodule
`default_nettype wire
